/* src/cssc_pkg.sv */
// ----------------------------------------------------------------------------
// cssc_pkg
// Shared types and constants of the camera scaler setup calculator.
// ----------------------------------------------------------------------------
package cssc_pkg;

  // Field widths.
  localparam int DIM_W   = 13;  // pixel counts
  localparam int BYTES_W = 15;  // line byte count
  localparam int RATIO_W = 6;   // pre-scale ratio 1..32
  localparam int SHIFT_W = 3;   // pre-scale shift 0..5
  localparam int SF_W    = 4;   // shift factor 0..10
  localparam int BURST_W = 5;   // burst lengths 1..16

  // Divider widths: dividend is source << 8, divisor is target << shift.
  localparam int FRAC_W = 8;
  localparam int REM_W  = DIM_W + FRAC_W;        // 21
  localparam int DVSR_W = DIM_W + 5;             // 18
  localparam int QUO_W  = 9;                     // quotient stays below 512
  localparam int CMP_W  = DVSR_W + QUO_W;        // widest shifted divisor

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 1'b1;

  // Reset values of the source window.
  localparam logic [DIM_W-1:0] SOURCE_WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] SOURCE_HEIGHT_RESET = 13'd480;

  // One axis of the divider.
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DVSR_W-1:0] dvsr;
    logic [QUO_W-1:0]  quo;
  } cssc_axis_t;

  // Results that are final after the setup cell and ride along the chain.
  typedef struct packed {
    logic [RATIO_W-1:0] pre_hor_ratio;
    logic [RATIO_W-1:0] pre_ver_ratio;
    logic [DIM_W-1:0]   pre_dst_width;
    logic [DIM_W-1:0]   pre_dst_height;
    logic [SF_W-1:0]    shift_factor;
    logic               scale_up;
    logic [BURST_W-1:0] burst_len;
    logic [BURST_W-1:0] last_burst;
    logic               range_error;
  } cssc_side_t;

  // Payload handed from cell to cell.
  typedef struct packed {
    cssc_side_t side;
    cssc_axis_t hor;
    cssc_axis_t ver;
  } cssc_data_t;

endpackage

/* src/cssc_setup.sv */
// ----------------------------------------------------------------------------
// cssc_setup
// Head cell: picks the pre-scale shift per axis, checks the range, computes
// the burst lengths and loads the divider operands.
// ----------------------------------------------------------------------------
module cssc_setup
  import cssc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DIM_W-1:0]   source_width,
  input  logic [DIM_W-1:0]   source_height,
  input  logic [DIM_W-1:0]   target_width,
  input  logic [DIM_W-1:0]   target_height,
  input  logic [BYTES_W-1:0] line_bytes,
  output logic               out_valid,
  input  logic               out_ready,
  output cssc_data_t         out_data
);

  localparam int MAX_SHIFT   = 5;
  localparam int RANGE_SHIFT = 6;
  localparam int CMP19_W     = DIM_W + RANGE_SHIFT;
  localparam logic [SF_W-1:0]    SHIFT_BASE = 4'd10;
  localparam logic [BURST_W-1:0] BURST_16   = 5'd16;
  localparam logic [BURST_W-1:0] BURST_8    = 5'd8;
  localparam logic [BURST_W-1:0] BURST_4    = 5'd4;

  typedef struct packed {
    logic               err;
    logic [SHIFT_W-1:0] shift;
  } cssc_pick_t;

  // Largest shift with source >= target << shift; error when the source is
  // at least 64 times the target, a zero target included.
  function automatic cssc_pick_t pick(input logic [DIM_W-1:0] src,
                                      input logic [DIM_W-1:0] tar);
    cssc_pick_t p;
    logic [CMP19_W-1:0] s_ext;
    logic [CMP19_W-1:0] t_ext;
    s_ext   = CMP19_W'(src);
    t_ext   = CMP19_W'(tar);
    p.err   = s_ext >= (t_ext << RANGE_SHIFT);
    p.shift = '0;
    for (int s = 1; s <= MAX_SHIFT; s++) begin
      if (s_ext >= (t_ext << s)) begin
        p.shift = SHIFT_W'(s);
      end
    end
    return p;
  endfunction

  cssc_pick_t         hp;
  cssc_pick_t         vp;
  logic               err;
  logic [3:0]         m16;
  logic [2:0]         m8;
  logic [1:0]         m4;
  cssc_data_t         data_next;
  logic               valid;
  cssc_data_t         data;

  // Operand and side-result computation.
  always_comb begin
    hp  = pick(source_width, target_width);
    vp  = pick(source_height, target_height);
    err = hp.err | vp.err;
    m16 = line_bytes[5:2];
    m8  = line_bytes[4:2];
    m4  = line_bytes[3:2];

    data_next                  = '0;
    data_next.side.range_error = err;
    data_next.side.scale_up    = (target_width >= source_width);

    if (err) begin
      // Zero remainder against a nonzero divisor yields a zero quotient.
      data_next.hor.dvsr = '1;
      data_next.ver.dvsr = '1;
    end else begin
      data_next.side.pre_hor_ratio  = RATIO_W'(1) << hp.shift;
      data_next.side.pre_ver_ratio  = RATIO_W'(1) << vp.shift;
      data_next.side.pre_dst_width  = source_width >> hp.shift;
      data_next.side.pre_dst_height = source_height >> vp.shift;
      data_next.side.shift_factor   = SHIFT_BASE - SF_W'(hp.shift) - SF_W'(vp.shift);
      data_next.hor.rem  = {source_width, FRAC_W'(0)};
      data_next.hor.dvsr = DVSR_W'(target_width) << hp.shift;
      data_next.ver.rem  = {source_height, FRAC_W'(0)};
      data_next.ver.dvsr = DVSR_W'(target_height) << vp.shift;
    end

    // Burst choice from the word count of a line.
    if (m16 inside {4'd0, 4'd4, 4'd8}) begin
      data_next.side.burst_len  = BURST_16;
      data_next.side.last_burst = (m16 == 4'd0) ? BURST_16 : BURST_W'(m16);
    end else if (m8 inside {3'd0, 3'd4}) begin
      data_next.side.burst_len  = BURST_8;
      data_next.side.last_burst = (m8 == 3'd0) ? BURST_8 : BURST_4;
    end else begin
      data_next.side.burst_len  = BURST_4;
      data_next.side.last_burst = (m4 != 2'd0) ? BURST_W'(m4) : BURST_4;
    end
  end

  // Cell register with its own handshake.
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

/* src/cssc_div_cell.sv */
// ----------------------------------------------------------------------------
// cssc_div_cell
// One restoring-division cell: settles one quotient bit on both axes and
// hands the partial remainder to the next cell.
// ----------------------------------------------------------------------------
module cssc_div_cell
  import cssc_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  cssc_data_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output cssc_data_t out_data
);

  // Compare the remainder against the divisor weighted by this bit.
  function automatic cssc_axis_t step(input cssc_axis_t a);
    logic [CMP_W-1:0] trial;
    trial = CMP_W'(a.dvsr) << BIT;
    if (CMP_W'(a.rem) >= trial) begin
      a.rem      = a.rem - trial[REM_W-1:0];
      a.quo[BIT] = 1'b1;
    end
    return a;
  endfunction

  cssc_data_t data_next;
  cssc_data_t data;
  logic       valid;

  always_comb begin
    data_next     = in_data;
    data_next.hor = step(in_data.hor);
    data_next.ver = step(in_data.ver);
  end

  // Cell register; a transfer happens when the cell is empty or drains.
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

/* src/camera_scaler_setup_calc_core.sv */
// ----------------------------------------------------------------------------
// camera_scaler_setup_calc_core
// Camera preview scaler setup calculator: pre-scale, main ratio and bursts.
// ----------------------------------------------------------------------------
// The block accepts one setup item per clock cycle while the output is not
// stalled: one head cell picks the pre-scale shifts and the burst lengths,
// then a row of nine divider cells settles the main ratios, one quotient bit
// per cell on both axes at once. Each cell has its own register and handshake,
// so a stalled output only holds the cells behind it that are full. The user
// writes the source window size through the configuration port while no item
// is in flight; the block does not check it. The window resets to 640 by 480.
module camera_scaler_setup_calc_core
  import cssc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Configuration
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  // Input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DIM_W-1:0]     target_width,
  input  logic [DIM_W-1:0]     target_height,
  input  logic [BYTES_W-1:0]   line_bytes,
  // Output channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [RATIO_W-1:0]   pre_hor_ratio,
  output logic [RATIO_W-1:0]   pre_ver_ratio,
  output logic [DIM_W-1:0]     pre_dst_width,
  output logic [DIM_W-1:0]     pre_dst_height,
  output logic [QUO_W-1:0]     main_hor_ratio,
  output logic [QUO_W-1:0]     main_ver_ratio,
  output logic [SF_W-1:0]      shift_factor,
  output logic                 scale_up,
  output logic [BURST_W-1:0]   burst_len,
  output logic [BURST_W-1:0]   last_burst,
  output logic                 range_error
);

  logic [DIM_W-1:0] source_width;
  logic [DIM_W-1:0] source_height;

  logic       stg_valid [QUO_W+1];
  logic       stg_ready [QUO_W+1];
  cssc_data_t stg_data  [QUO_W+1];

  // Source window registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SOURCE_WIDTH_RESET;
      source_height <= SOURCE_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        REG_SOURCE_HEIGHT: source_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Head cell.
  cssc_setup u_setup (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .source_width  (source_width),
    .source_height (source_height),
    .target_width  (target_width),
    .target_height (target_height),
    .line_bytes    (line_bytes),
    .out_valid     (stg_valid[0]),
    .out_ready     (stg_ready[0]),
    .out_data      (stg_data[0])
  );

  // Divider cells, most significant quotient bit first.
  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    cssc_div_cell #(
      .BIT (QUO_W - 1 - i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[i]),
      .in_ready  (stg_ready[i]),
      .in_data   (stg_data[i]),
      .out_valid (stg_valid[i+1]),
      .out_ready (stg_ready[i+1]),
      .out_data  (stg_data[i+1])
    );
  end

  // The last cell register is the output register.
  assign stg_ready[QUO_W] = out_ready;
  assign out_valid        = stg_valid[QUO_W];
  assign pre_hor_ratio    = stg_data[QUO_W].side.pre_hor_ratio;
  assign pre_ver_ratio    = stg_data[QUO_W].side.pre_ver_ratio;
  assign pre_dst_width    = stg_data[QUO_W].side.pre_dst_width;
  assign pre_dst_height   = stg_data[QUO_W].side.pre_dst_height;
  assign main_hor_ratio   = stg_data[QUO_W].hor.quo;
  assign main_ver_ratio   = stg_data[QUO_W].ver.quo;
  assign shift_factor     = stg_data[QUO_W].side.shift_factor;
  assign scale_up         = stg_data[QUO_W].side.scale_up;
  assign burst_len        = stg_data[QUO_W].side.burst_len;
  assign last_burst       = stg_data[QUO_W].side.last_burst;
  assign range_error      = stg_data[QUO_W].side.range_error;

endmodule

/* src/cssc_checker.sv */
// ----------------------------------------------------------------------------
// cssc_checker
// Port-level checks of the scaler setup calculator, bound to the top level.
// ----------------------------------------------------------------------------
module cssc_checker
  import cssc_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [RATIO_W-1:0]   pre_hor_ratio,
  input logic [RATIO_W-1:0]   pre_ver_ratio,
  input logic [DIM_W-1:0]     pre_dst_width,
  input logic [QUO_W-1:0]     main_hor_ratio,
  input logic [QUO_W-1:0]     main_ver_ratio,
  input logic [SF_W-1:0]      shift_factor,
  input logic [BURST_W-1:0]   burst_len,
  input logic [BURST_W-1:0]   last_burst,
  input logic                 range_error
);

  // A result on a range error carries no ratio settings.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |->
      pre_hor_ratio == '0 && pre_ver_ratio == '0 && main_hor_ratio == '0 &&
      main_ver_ratio == '0 && shift_factor == '0)
  else $error("range error result carries nonzero ratio fields");

  // Without a range error the pre-scale ratios are powers of two.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !range_error |->
      $onehot(pre_hor_ratio) && $onehot(pre_ver_ratio))
  else $error("pre-scale ratio is not a power of two");

  // The burst is 4, 8 or 16 long; the last burst of a line is nonzero and never longer than the main burst.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (burst_len == 5'd4 || burst_len == 5'd8 || burst_len == 5'd16) &&
      last_burst != '0 && last_burst <= burst_len)
  else $error("inconsistent burst lengths");

  // A stalled result holds until its transfer.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(main_hor_ratio) && $stable(main_ver_ratio) &&
      $stable(pre_dst_width) && $stable(range_error))
  else $error("stalled result changed before transfer");

endmodule

bind camera_scaler_setup_calc_core cssc_checker u_cssc_checker (.*);
